// ===== sv/rc4_pkg.sv =====
// Shared types, codes and control store for the RC4 stream cipher engine.
// Depends on nothing; used by the engine and its checker.
package rc4_pkg;

  localparam int KEY_DEPTH_DEF = 256;
  localparam int PERM_SIZE     = 256;
  localparam int LEN_W         = 9;

  localparam logic [LEN_W-1:0] KEY_LEN_RESET = LEN_W'(16);
  localparam logic [LEN_W-1:0] KEY_LEN_MIN   = LEN_W'(3);

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_SCHEDULE = 2'd1;
  localparam logic [1:0] CMD_ENCRYPT  = 2'd2;

  localparam logic [1:0] KIND_CIPHER    = 2'd0;
  localparam logic [1:0] KIND_DONE      = 2'd1;
  localparam logic [1:0] KIND_NOT_KEYED = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] key_index;
    logic [7:0] data_byte;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] keystream_byte;
    logic [7:0] cipher_byte;
  } result_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_NOKEY, ST_INIT,
    ST_K0, ST_K1, ST_K2, ST_K3, ST_KEND,
    ST_E0, ST_E1, ST_E2, ST_E3, ST_E4
  } step_t;

  typedef enum logic [2:0] {RA_NONE, RA_I, RA_I_NEXT, RA_J_NEXT, RA_SUM} ra_t;
  typedef enum logic [1:0] {WR_NONE, WR_I_IDX, WR_I_Q, WR_J_A} wr_t;
  typedef enum logic [1:0] {J_HOLD, J_KSA, J_PRGA, J_CLEAR} jsel_t;
  typedef enum logic [1:0] {EM_NONE, EM_DONE, EM_CIPHER, EM_NOKEY} emit_t;
  typedef enum logic [1:0] {JMP_NEXT, JMP_DISPATCH, JMP_LOOP, JMP_IDLE} jmp_t;

  typedef struct packed {
    ra_t   ra;
    wr_t   wr;
    jsel_t jsel;
    logic  i_inc;
    logic  a_load;
    logic  b_load;
    logic  key_rd;
    logic  key_we;
    logic  kpos_clr;
    logic  kpos_adv;
    logic  set_keyed;
    emit_t emit;
    jmp_t  jmp;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t u;
    u = '0;
    case (s)
      ST_IDLE: begin
        u.jmp = JMP_DISPATCH;
      end
      ST_LOAD: begin
        u.key_we = 1'b1;
        u.jmp    = JMP_IDLE;
      end
      ST_NOKEY: begin
        u.emit = EM_NOKEY;
        u.jmp  = JMP_IDLE;
      end
      ST_INIT: begin
        u.wr       = WR_I_IDX;
        u.i_inc    = 1'b1;
        u.kpos_clr = 1'b1;
        u.jsel     = J_CLEAR;
        u.jmp      = JMP_LOOP;
        u.target   = ST_INIT;
      end
      ST_K0: begin
        u.ra     = RA_I;
        u.key_rd = 1'b1;
      end
      ST_K1: begin
        u.a_load = 1'b1;
        u.jsel   = J_KSA;
        u.ra     = RA_J_NEXT;
      end
      ST_K2: begin
        u.wr = WR_I_Q;
      end
      ST_K3: begin
        u.wr       = WR_J_A;
        u.i_inc    = 1'b1;
        u.kpos_adv = 1'b1;
        u.jmp      = JMP_LOOP;
        u.target   = ST_K0;
      end
      ST_KEND: begin
        u.jsel      = J_CLEAR;
        u.set_keyed = 1'b1;
        u.emit      = EM_DONE;
        u.jmp       = JMP_IDLE;
      end
      ST_E0: begin
        u.ra    = RA_I_NEXT;
        u.i_inc = 1'b1;
      end
      ST_E1: begin
        u.a_load = 1'b1;
        u.jsel   = J_PRGA;
        u.ra     = RA_J_NEXT;
      end
      ST_E2: begin
        u.wr     = WR_I_Q;
        u.b_load = 1'b1;
      end
      ST_E3: begin
        u.wr = WR_J_A;
        u.ra = RA_SUM;
      end
      ST_E4: begin
        u.emit = EM_CIPHER;
        u.jmp  = JMP_IDLE;
      end
      default: begin
        u.jmp = JMP_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

// ===== sv/rc4_stream_cipher.sv =====
// RC4 stream cipher engine: microcoded sequencer over permutation and key memories.
// Depends on rc4_pkg for item types, codes and the control store.
//
// One command per input transfer. A key load gives no result.
// A key schedule first sets the identity permutation, then runs each schedule
// step as dependent accesses over the one read port and one write port of the
// permutation memory (read S[i], read S[j], write S[i], write S[j]). An encrypt
// registers its result after three dependent permutation reads and two writes.
// An encrypt before any schedule returns a not-keyed result.
// A finished result waits in an output register while the next command is taken.
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEN_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  cmd_item_t          in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output result_item_t       out_data
);

  localparam int KW = $clog2(KEY_DEPTH);
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(KEY_DEPTH);

  step_t           pc, pc_next;
  ucode_t          uw;
  cmd_item_t       cmd_q;
  logic            keyed;
  logic [7:0]      i, j, j_next, a, b;
  logic [KW-1:0]   kpos;
  logic [7:0]      key_q;
  logic [LEN_W-1:0] key_length, eff_len;
  logic            accept, stall, go;

  logic [7:0]      perm_mem [PERM_SIZE];
  logic [7:0]      key_mem  [KEY_DEPTH];
  logic [7:0]      perm_rd_q, byp_data, perm_out;
  logic            byp_hit;
  logic [7:0]      perm_ra, perm_wa, perm_wd;
  logic            perm_re, perm_we, key_wr, kpos_wrap;

  assign uw        = ucode_rom(pc);
  assign in_ready  = (pc == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign stall     = (uw.emit != EM_NONE) && out_valid && !out_ready;
  assign go        = !stall;

  always_comb begin
    if (key_length < KEY_LEN_MIN) begin
      eff_len = KEY_LEN_MIN;
    end else if (key_length > DEPTH_LEN) begin
      eff_len = DEPTH_LEN;
    end else begin
      eff_len = key_length;
    end
  end

  assign kpos_wrap = (LEN_W'(kpos) + LEN_W'(1)) >= eff_len;
  assign perm_out  = byp_hit ? byp_data : perm_rd_q;

  always_comb begin
    pc_next = pc;
    if (go) begin
      case (uw.jmp)
        JMP_NEXT: begin
          pc_next = step_t'(4'(pc + 4'd1));
        end
        JMP_DISPATCH: begin
          if (accept) begin
            case (in_data.command)
              CMD_LOAD:     pc_next = ST_LOAD;
              CMD_SCHEDULE: pc_next = ST_INIT;
              CMD_ENCRYPT:  pc_next = keyed ? ST_E0 : ST_NOKEY;
              default:      pc_next = ST_IDLE;
            endcase
          end
        end
        JMP_LOOP: begin
          pc_next = (i != 8'hFF) ? uw.target : step_t'(4'(pc + 4'd1));
        end
        JMP_IDLE: begin
          pc_next = ST_IDLE;
        end
        default: begin
          pc_next = ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    case (uw.jsel)
      J_KSA:   j_next = j + perm_out + key_q;
      J_PRGA:  j_next = j + perm_out;
      J_CLEAR: j_next = 8'd0;
      default: j_next = j;
    endcase
  end

  always_comb begin
    case (uw.ra)
      RA_I:      perm_ra = i;
      RA_I_NEXT: perm_ra = i + 8'd1;
      RA_J_NEXT: perm_ra = j_next;
      RA_SUM:    perm_ra = a + b;
      default:   perm_ra = i;
    endcase
    case (uw.wr)
      WR_I_IDX: begin
        perm_wa = i;
        perm_wd = i;
      end
      WR_I_Q: begin
        perm_wa = i;
        perm_wd = perm_out;
      end
      WR_J_A: begin
        perm_wa = j;
        perm_wd = a;
      end
      default: begin
        perm_wa = i;
        perm_wd = i;
      end
    endcase
  end

  assign perm_re = go && (uw.ra != RA_NONE);
  assign perm_we = go && (uw.wr != WR_NONE);
  assign key_wr  = go && uw.key_we && ({1'b0, cmd_q.key_index} < DEPTH_LEN);

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_wa] <= perm_wd;
    end
    if (perm_re) begin
      perm_rd_q <= perm_mem[perm_ra];
      byp_hit   <= perm_we && (perm_wa == perm_ra);
      byp_data  <= perm_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_mem[cmd_q.key_index[KW-1:0]] <= cmd_q.data_byte;
    end
    if (go && uw.key_rd) begin
      key_q <= key_mem[kpos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= ST_IDLE;
      keyed      <= 1'b0;
      i          <= 8'd0;
      j          <= 8'd0;
      out_valid  <= 1'b0;
      key_length <= KEY_LEN_RESET;
    end else begin
      pc <= pc_next;
      if (cfg_valid && cfg_ready) begin
        key_length <= cfg_data;
      end
      if (go && uw.i_inc) begin
        i <= i + 8'd1;
      end else if (accept && (in_data.command == CMD_SCHEDULE)) begin
        i <= 8'd0;
      end
      if (go) begin
        j <= j_next;
      end
      if (go && uw.set_keyed) begin
        keyed <= 1'b1;
      end
      if (go && (uw.emit != EM_NONE)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= in_data;
    end
    if (go && uw.a_load) begin
      a <= perm_out;
    end
    if (go && uw.b_load) begin
      b <= perm_out;
    end
    if (go && uw.kpos_clr) begin
      kpos <= '0;
    end else if (go && uw.kpos_adv) begin
      kpos <= kpos_wrap ? '0 : KW'(kpos + 1'b1);
    end
    if (go) begin
      case (uw.emit)
        EM_DONE: begin
          out_data <= '{result_kind: KIND_DONE, keystream_byte: 8'd0, cipher_byte: 8'd0};
        end
        EM_CIPHER: begin
          out_data <= '{result_kind: KIND_CIPHER, keystream_byte: perm_out,
                        cipher_byte: cmd_q.data_byte ^ perm_out};
        end
        EM_NOKEY: begin
          out_data <= '{result_kind: KIND_NOT_KEYED, keystream_byte: 8'd0,
                        cipher_byte: cmd_q.data_byte};
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/rc4_checker.sv =====
// Port-level checks for the RC4 stream cipher engine, bound to its top level.
// Depends on rc4_pkg for item types and codes.
module rc4_checker
  import rc4_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input cmd_item_t    in_data,
  input logic         out_valid,
  input logic         out_ready,
  input result_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind == KIND_DONE) |->
      (out_data.keystream_byte == 8'd0) && (out_data.cipher_byte == 8'd0))
    else $error("schedule done result carries data");

  a_nokey_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind == KIND_NOT_KEYED) |->
      (out_data.keystream_byte == 8'd0))
    else $error("not-keyed result carries keystream");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_valid && in_ready && (in_data.command == CMD_LOAD) |=> !out_valid)
    else $error("key load produced a result");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);

// ===== tb/rc4_stream_cipher_tb.sv =====
// Self-checking testbench for rc4_stream_cipher: directed and random command traffic
// with a cycle-free RC4 predictor and per-field result checks.
// Depends on rc4_pkg and the rc4_stream_cipher RTL only.
`timescale 1ns / 100ps

module rc4_stream_cipher_tb;
  import rc4_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LEN_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  cmd_item_t          in_data;
  logic               out_valid;
  logic               out_ready;
  result_item_t       out_data;

  logic [7:0]         perm_state [256];
  logic [7:0]         key_mem [256];
  bit                 key_loaded [256];
  logic [7:0]         idx_i;
  logic [7:0]         idx_j;
  bit                 keyed;
  logic [LEN_W-1:0]   key_len_cfg;

  result_item_t       rc4_results_due [$];
  int                 errors;
  int                 sender_idle_pct;
  int                 rx_stall_pct;

  rc4_stream_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("rc4_stream_cipher_tb NOT OK");
    $finish;
  end

  function automatic int unsigned active_key_len();
    if (key_len_cfg < KEY_LEN_MIN) return 3;
    if (key_len_cfg > KEY_DEPTH_DEF) return KEY_DEPTH_DEF;
    return 32'(key_len_cfg);
  endfunction

  function automatic void run_key_schedule();
    int unsigned len;
    logic [7:0]  j;
    logic [7:0]  t;
    len = active_key_len();
    for (int n = 0; n < PERM_SIZE; n++) perm_state[n] = 8'(n);
    j = 8'd0;
    for (int n = 0; n < PERM_SIZE; n++) begin
      j = j + perm_state[n] + key_mem[n % len];
      t = perm_state[n];
      perm_state[n] = perm_state[j];
      perm_state[j] = t;
    end
    idx_i = 8'd0;
    idx_j = 8'd0;
    keyed = 1'b1;
  endfunction

  function automatic logic [7:0] next_keystream();
    logic [7:0] t;
    logic [7:0] sum;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm_state[idx_i];
    t = perm_state[idx_i];
    perm_state[idx_i] = perm_state[idx_j];
    perm_state[idx_j] = t;
    sum = perm_state[idx_i] + perm_state[idx_j];
    return perm_state[sum];
  endfunction

  function automatic void rc4_apply_cmd(cmd_item_t c);
    result_item_t r;
    logic [7:0]   ks;
    case (c.command)
      CMD_LOAD: begin
        key_mem[c.key_index] = c.data_byte;
        key_loaded[c.key_index] = 1'b1;
      end
      CMD_SCHEDULE: begin
        run_key_schedule();
        r.result_kind = KIND_DONE;
        r.keystream_byte = 8'd0;
        r.cipher_byte = 8'd0;
        rc4_results_due.push_back(r);
      end
      CMD_ENCRYPT: begin
        if (!keyed) begin
          r.result_kind = KIND_NOT_KEYED;
          r.keystream_byte = 8'd0;
          r.cipher_byte = c.data_byte;
        end else begin
          ks = next_keystream();
          r.result_kind = KIND_CIPHER;
          r.keystream_byte = ks;
          r.cipher_byte = c.data_byte ^ ks;
        end
        rc4_results_due.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic cmd_item_t make_cmd(logic [1:0] command, logic [7:0] kidx,
                                         logic [7:0] data);
    cmd_item_t c;
    c.command = command;
    c.key_index = kidx;
    c.data_byte = data;
    return c;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_cmd(cmd_item_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    rc4_apply_cmd(c);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (rc4_results_due.size() != 0 && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    // allow a trailing key load to finish
    repeat (12) @(posedge clk);
  endtask

  task automatic write_key_length(logic [LEN_W-1:0] len);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    key_len_cfg = len;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // reload short keys in full; long keys only where never loaded
  task automatic send_key_and_schedule();
    int unsigned len;
    len = active_key_len();
    for (int k = 0; k < len; k++)
      if (len <= 32 || !key_loaded[k])
        send_cmd(make_cmd(CMD_LOAD, 8'(k), rand_byte()));
    send_cmd(make_cmd(CMD_SCHEDULE, rand_byte(), rand_byte()));
  endtask

  task automatic test_unkeyed_encrypt();
    send_cmd(make_cmd(CMD_ENCRYPT, 8'hFF, 8'h00));
    send_cmd(make_cmd(CMD_ENCRYPT, 8'h00, 8'hFF));
    send_cmd(make_cmd(CMD_UNUSED, 8'hFF, 8'hFF));
    send_cmd(make_cmd(CMD_ENCRYPT, 8'h5A, 8'h5A));
  endtask

  task automatic test_default_key_length();
    for (int k = 0; k < 16; k++)
      send_cmd(make_cmd(CMD_LOAD, 8'(k), (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : rand_byte()));
    send_cmd(make_cmd(CMD_SCHEDULE, 8'h00, 8'h00));
    send_cmd(make_cmd(CMD_ENCRYPT, 8'h00, 8'h00));
    send_cmd(make_cmd(CMD_ENCRYPT, 8'hFF, 8'hFF));
  endtask

  task automatic test_key_reload();
    send_cmd(make_cmd(CMD_LOAD, 8'hFF, 8'hFF));
    send_cmd(make_cmd(CMD_LOAD, 8'h00, 8'h80));
    send_cmd(make_cmd(CMD_ENCRYPT, 8'h12, 8'h3C));
    send_cmd(make_cmd(CMD_SCHEDULE, 8'hFF, 8'hFF));
    send_cmd(make_cmd(CMD_ENCRYPT, 8'h34, 8'hC3));
  endtask

  task automatic test_key_length_sweep();
    logic [LEN_W-1:0] lengths [8];
    int unsigned      pick;
    lengths = '{9'd0, 9'd3, 9'd256, 9'd511, 9'd2, 9'd257, 9'd16, 9'd40};
    for (int p = 0; p < 8; p++) begin
      drain_results();
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 46;
          rx_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          rx_stall_pct = 46;
        end
        default: begin
          sender_idle_pct = 15;
          rx_stall_pct = 15;
        end
      endcase
      write_key_length((p == 6) ? LEN_W'($urandom_range(3, 64)) : lengths[p]);
      send_key_and_schedule();
      for (int n = 0; n < 40; n++) begin
        pick = $urandom_range(99);
        if (pick < 6)
          send_key_and_schedule();
        else if (pick < 11)
          send_cmd(make_cmd(CMD_UNUSED, rand_byte(), rand_byte()));
        else if (pick < 24)
          send_cmd(make_cmd(CMD_LOAD, rand_byte(), rand_byte()));
        else
          send_cmd(make_cmd(CMD_ENCRYPT, rand_byte(), rand_byte()));
      end
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (rc4_results_due.size() == 0) begin
        $error("unexpected result: result_kind %0d keystream_byte %02h cipher_byte %02h",
               out_data.result_kind, out_data.keystream_byte, out_data.cipher_byte);
        errors++;
      end else begin
        want = rc4_results_due.pop_front();
        if (out_data.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind,
                 out_data.result_kind);
          errors++;
        end
        if (out_data.keystream_byte !== want.keystream_byte) begin
          $error("keystream_byte: expected %02h, got %02h", want.keystream_byte,
                 out_data.keystream_byte);
          errors++;
        end
        if (out_data.cipher_byte !== want.cipher_byte) begin
          $error("cipher_byte: expected %02h, got %02h", want.cipher_byte,
                 out_data.cipher_byte);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    errors = 0;
    sender_idle_pct = 0;
    rx_stall_pct = 0;
    key_len_cfg = KEY_LEN_RESET;
    keyed = 1'b0;
    idx_i = 8'd0;
    idx_j = 8'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_unkeyed_encrypt();
    test_default_key_length();
    test_key_reload();
    test_key_length_sweep();
    drain_results();
    if (rc4_results_due.size() != 0) begin
      $error("%0d results never arrived", rc4_results_due.size());
      errors++;
    end
    if (errors == 0)
      $display("rc4_stream_cipher_tb OK");
    else
      $display("rc4_stream_cipher_tb NOT OK");
    $finish;
  end

endmodule
